[design/mslf_pkg.sv]
// ---------------------------------------------------------------------------
// mslf_pkg
// Shared types and constants of the magic-synchronized length deframer.
// ---------------------------------------------------------------------------
package mslf_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_FRAME_MODE   = 2'd0;
    localparam logic [1:0] CFG_MAGIC_FIRST  = 2'd1;
    localparam logic [1:0] CFG_MAGIC_SECOND = 2'd2;
    localparam logic [1:0] CFG_MIN_TOTAL    = 2'd3;

    // Request kinds carried in tuser
    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_DROP = 1'b1;

    // Frame modes
    localparam logic MODE_SHORT = 1'b0;
    localparam logic MODE_LONG  = 1'b1;

    // Header lengths and fixed limits
    localparam logic [3:0]  HDR_SHORT     = 4'd6;
    localparam logic [3:0]  HDR_LONG      = 4'd8;
    localparam logic [16:0] LONG_EXTRA    = 17'd8;
    localparam logic [16:0] LONG_MIN      = 17'd8;
    localparam logic [9:0]  SHORT_MIN     = 10'd6;

    // Reset values of the configuration registers
    localparam logic [7:0]  MAGIC_RST     = 8'h5A;
    localparam logic [9:0]  MIN_TOTAL_RST = 10'd40;

    localparam int CFG_DATA_W = 10;
    localparam int TOTAL_W    = 17;
    localparam int OFFSET_W   = 9;

    typedef logic [7:0][7:0] t_hdr;

    typedef struct packed {
        logic       frame_mode;
        logic [7:0] magic_first;
        logic [7:0] magic_second;
        logic [9:0] min_total;
    } t_cfg;

    // One burst of result items handed from the framer to the emitter
    typedef struct packed {
        logic               load;
        logic               bad;
        logic [2:0]         len_m1;
        logic [TOTAL_W-1:0] total;
        t_hdr               bytes;
    } t_evt;

endpackage

[design/mslf_cfg.sv]
// ---------------------------------------------------------------------------
// mslf_cfg
// Configuration register file; flags a frame mode write so that the framer
// drops any partial assembly.
// ---------------------------------------------------------------------------
module mslf_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [mslf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output mslf_pkg::t_cfg                o_cfg,
    output logic                          o_mode_wr
);
    import mslf_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic n_mode_wr;

    // Decode the write
    always_comb begin
        n_cfg     = r_cfg;
        n_mode_wr = 1'b0;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRAME_MODE: begin
                    n_cfg.frame_mode = i_cfg_data[0];
                    n_mode_wr        = 1'b1;
                end
                CFG_MAGIC_FIRST:  n_cfg.magic_first  = i_cfg_data[7:0];
                CFG_MAGIC_SECOND: n_cfg.magic_second = i_cfg_data[7:0];
                CFG_MIN_TOTAL:    n_cfg.min_total    = i_cfg_data[9:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_mode   <= MODE_SHORT;
            r_cfg.magic_first  <= MAGIC_RST;
            r_cfg.magic_second <= MAGIC_RST;
            r_cfg.min_total    <= MIN_TOTAL_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Clear the assembly at the same edge that takes the mode write
    assign o_cfg     = r_cfg;
    assign o_mode_wr = n_mode_wr;

endmodule

[design/mslf_framer.sv]
// ---------------------------------------------------------------------------
// mslf_framer
// Hunts for the start magic, collects the header, checks the declared total
// and tracks the body offset. Hands at most one burst of result items per item.
// ---------------------------------------------------------------------------
module mslf_framer #(
    parameter int BUF_BYTES = 512
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mslf_pkg::t_cfg i_cfg,
    input  logic           i_mode_wr,
    input  logic           i_accept,
    input  logic           i_req_type,
    input  logic [7:0]     i_data_byte,
    output mslf_pkg::t_evt o_evt,
    output logic [$clog2(BUF_BYTES+1)-1:0] o_evt_off
);
    import mslf_pkg::*;

    localparam int W = $clog2(BUF_BYTES + 1);
    localparam logic [TOTAL_W-1:0] BUF_LIM = TOTAL_W'(BUF_BYTES);

    t_hdr         r_hdr;
    logic [3:0]   r_cnt;
    logic         r_in_body;
    logic [W-1:0] r_body_off;
    logic [W-1:0] r_pkt_total;

    t_hdr         n_hdr;
    logic [3:0]   n_cnt;
    logic         n_in_body;
    logic [W-1:0] n_body_off;
    logic [W-1:0] n_pkt_total;

    t_hdr               w_hdr;
    logic [2:0]         wr_idx;
    logic [3:0]         cnt1;
    logic               mismatch;
    logic [3:0]         hlen;
    logic [TOTAL_W-1:0] total;
    logic [TOTAL_W-1:0] lo;
    logic               size_bad;
    logic               body_last;
    logic [W:0]         body_next;

    // Header write, magic check and total decode
    always_comb begin
        wr_idx = (r_cnt > 4'd7) ? 3'd0 : r_cnt[2:0];
        cnt1   = {1'b0, wr_idx} + 4'd1;
        w_hdr  = r_hdr;
        w_hdr[wr_idx] = i_data_byte;
        mismatch = (cnt1 >= 4'd2) &&
                   ((w_hdr[0] != i_cfg.magic_first) || (w_hdr[1] != i_cfg.magic_second));
        hlen = i_cfg.frame_mode ? HDR_LONG : HDR_SHORT;
        if (i_cfg.frame_mode) begin
            total = TOTAL_W'({w_hdr[2], w_hdr[3]}) + LONG_EXTRA;
            lo    = LONG_MIN;
        end else begin
            total = TOTAL_W'({w_hdr[5], w_hdr[4]});
            lo    = TOTAL_W'((i_cfg.min_total < SHORT_MIN) ? SHORT_MIN : i_cfg.min_total);
        end
        size_bad  = (total < lo) || (total > BUF_LIM);
        body_next = {1'b0, r_body_off} + (W+1)'(1);
        body_last = body_next >= {1'b0, r_pkt_total};
    end

    // Next state and result burst
    always_comb begin
        n_hdr       = r_hdr;
        n_cnt       = r_cnt;
        n_in_body   = r_in_body;
        n_body_off  = r_body_off;
        n_pkt_total = r_pkt_total;
        o_evt        = '0;
        o_evt_off    = '0;
        if (i_mode_wr) begin
            n_cnt       = 4'd0;
            n_in_body   = 1'b0;
            n_body_off  = '0;
            n_pkt_total = '0;
        end else if (i_accept) begin
            if (i_req_type == REQ_DROP) begin
                n_cnt       = 4'd0;
                n_in_body   = 1'b0;
                n_body_off  = '0;
                n_pkt_total = '0;
            end else if (r_in_body) begin
                // pass the body byte straight through
                o_evt.load     = 1'b1;
                o_evt.total    = TOTAL_W'(r_pkt_total);
                o_evt.bytes[0] = i_data_byte;
                o_evt_off      = r_body_off;
                if (body_last) begin
                    n_in_body   = 1'b0;
                    n_body_off  = '0;
                    n_pkt_total = '0;
                end else begin
                    n_body_off = body_next[W-1:0];
                end
            end else if (mismatch) begin
                // slide by one byte
                for (int i = 0; i < 7; i++) begin
                    n_hdr[i] = w_hdr[i+1];
                end
                n_hdr[7] = 8'd0;
                n_cnt    = cnt1 - 4'd1;
            end else if (cnt1 < hlen) begin
                n_hdr = w_hdr;
                n_cnt = cnt1;
            end else if (size_bad) begin
                o_evt.load  = 1'b1;
                o_evt.bad   = 1'b1;
                o_evt.total = total;
                n_cnt       = 4'd0;
            end else begin
                // release the whole header
                o_evt.load   = 1'b1;
                o_evt.len_m1 = 3'(hlen - 4'd1);
                o_evt.total  = total;
                o_evt.bytes  = w_hdr;
                n_cnt        = 4'd0;
                if (total != TOTAL_W'(hlen)) begin
                    n_in_body   = 1'b1;
                    n_body_off  = W'(hlen);
                    n_pkt_total = total[W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= 4'd0;
            r_in_body   <= 1'b0;
            r_body_off  <= '0;
            r_pkt_total <= '0;
        end else begin
            r_cnt       <= n_cnt;
            r_in_body   <= n_in_body;
            r_body_off  <= n_body_off;
            r_pkt_total <= n_pkt_total;
        end
    end

    // Header bytes are payload
    always_ff @(posedge i_clk) begin
        r_hdr <= n_hdr;
    end

endmodule

[design/mslf_emit.sv]
// ---------------------------------------------------------------------------
// mslf_emit
// Result register: holds one burst of result items and shifts it out one
// item per accepted output cycle.
// ---------------------------------------------------------------------------
module mslf_emit #(
    parameter int BUF_BYTES = 512
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mslf_pkg::t_evt i_evt,
    input  logic [$clog2(BUF_BYTES+1)-1:0] i_evt_off,
    output logic           o_in_ready,
    output logic           o_tvalid,
    input  logic           i_tready,
    output logic [39:0]    o_tdata,
    output logic           o_tlast,
    output logic [0:0]     o_tuser
);
    import mslf_pkg::*;

    localparam int W = $clog2(BUF_BYTES + 1);

    logic               r_busy;
    logic               r_bad;
    logic [2:0]         r_rem;
    logic [W-1:0]       r_off;
    logic [TOTAL_W-1:0] r_total;
    t_hdr               r_bytes;

    logic               beat;
    logic [TOTAL_W-1:0] off_ext;
    logic [TOTAL_W-1:0] off_next;

    assign beat       = r_busy && i_tready;
    assign o_in_ready = !r_busy || (i_tready && (r_rem == 3'd0));

    // Load a new burst or advance the current one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_evt.load) begin
            r_busy <= 1'b1;
        end else if (beat && (r_rem == 3'd0)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.load) begin
            r_bad   <= i_evt.bad;
            r_rem   <= i_evt.len_m1;
            r_off   <= i_evt_off;
            r_total <= i_evt.total;
            r_bytes <= i_evt.bytes;
        end else if (beat && (r_rem != 3'd0)) begin
            r_rem   <= r_rem - 3'd1;
            r_off   <= r_off + W'(1);
            r_bytes <= {8'd0, r_bytes[7:1]};
        end
    end

    // Present the current item
    always_comb begin
        off_ext  = TOTAL_W'(r_off);
        off_next = off_ext + TOTAL_W'(1);
        o_tvalid = r_busy;
        o_tdata  = {6'd0, r_total, off_ext[OFFSET_W-1:0], r_bytes[0]};
        o_tlast  = !r_bad && (off_next >= r_total);
        o_tuser  = r_bad;
    end

endmodule

[design/magic_sync_length_deframer.sv]
// ---------------------------------------------------------------------------
// magic_sync_length_deframer
// Byte-stream deframer: magic hunt, header length check, byte delivery with
// packet offset and end-of-packet flag.
// ---------------------------------------------------------------------------
//  channel  | dir | tdata                                   | tuser     | tlast
//  s_axis   | in  | [7:0] data_byte                         | req_type  | -
//  m_axis   | out | [7:0] out_byte, [16:8] byte_offset,     | bad_size  | last_byte
//           |     | [33:17] declared_total, [39:34] zero    |           |
//  cfg      | in  | i_cfg_we, i_cfg_idx, i_cfg_data (10 bits), no read-back
//
//  One input item per cycle while s_axis_tready is high. A body byte or an
//  error result is a single output item; a released header is 6 (mode 0) or
//  8 (mode 1) output items, shifted out by the result register one header
//  byte per accepted output cycle, and input is held off until the last is taken.
//  Synchronous active-low reset clears the assembly and the configuration.
//  An output stall holds the result register and stops input once it is full.
// ---------------------------------------------------------------------------
module magic_sync_length_deframer #(
    parameter int BUF_BYTES = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] out_byte, [16:8] byte_offset,
                                        // [33:17] declared_total
    output logic        m_axis_tlast,
    output logic [0:0]  m_axis_tuser,   // [0] bad_size
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [mslf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mslf_pkg::*;

    localparam int W = $clog2(BUF_BYTES + 1);

    t_cfg         cfg;
    logic         mode_wr;
    logic         accept;
    t_evt         evt;
    logic [W-1:0] evt_off;

    assign accept = s_axis_tvalid && s_axis_tready;

    mslf_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg),
        .o_mode_wr  (mode_wr)
    );

    mslf_framer #(
        .BUF_BYTES (BUF_BYTES)
    ) u_framer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_mode_wr   (mode_wr),
        .i_accept    (accept),
        .i_req_type  (s_axis_tuser[0]),
        .i_data_byte (s_axis_tdata),
        .o_evt       (evt),
        .o_evt_off   (evt_off)
    );

    mslf_emit #(
        .BUF_BYTES (BUF_BYTES)
    ) u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_evt      (evt),
        .i_evt_off  (evt_off),
        .o_in_ready (s_axis_tready),
        .o_tvalid   (m_axis_tvalid),
        .i_tready   (m_axis_tready),
        .o_tdata    (m_axis_tdata),
        .o_tlast    (m_axis_tlast),
        .o_tuser    (m_axis_tuser)
    );

endmodule

[design/mslf_checker.sv]
// ---------------------------------------------------------------------------
// mslf_checker
// Port-level checks of the deframer output stream.
// ---------------------------------------------------------------------------
module mslf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [0:0]  m_axis_tuser
);
    logic [16:0] off_next;

    assign off_next = {8'd0, m_axis_tdata[16:8]} + 17'd1;

    // Hold a stalled item
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output item changed");

    // Error result carries no byte, offset or end flag
    a_bad_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            !m_axis_tlast && (m_axis_tdata[16:0] == 17'd0))
        else $error("error result carries packet data");

    // End flag sits on the byte just before the declared total
    a_last_at_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> off_next == m_axis_tdata[33:17])
        else $error("last byte offset does not match total");

    // Packet bytes stay inside the declared total
    a_off_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> off_next <= m_axis_tdata[33:17])
        else $error("byte offset beyond declared total");

endmodule

bind magic_sync_length_deframer mslf_checker u_mslf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

[verif/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top
// Stream testbench for the magic-synchronized length deframer: a queue-fed
// driver with bursts and gaps, a receiver with its own stall pattern, and an
// in-line deframer predictor whose expected result items are checked field
// by field as they leave the block. Register settings change between
// phases while the block is idle.
// ---------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mslf_pkg::*;

    localparam int FRAME_CAP     = 512;
    localparam int SETTLE_CYCLES = 24;

    // One link item and one delivered result item
    typedef struct packed {
        logic       req;
        logic [7:0] data;
    } t_link_item;

    typedef struct packed {
        logic [7:0]          out_byte;
        logic [OFFSET_W-1:0] byte_offset;
        logic                last_byte;
        logic                bad_size;
        logic [TOTAL_W-1:0]  declared_total;
    } t_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;    // [7:0] data_byte
    logic [0:0]  s_axis_tuser = 1'b0;    // [0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;           // [7:0] out_byte, [16:8] byte_offset,
                                         // [33:17] declared_total
    logic        m_axis_tlast;
    logic [0:0]  m_axis_tuser;           // [0] bad_size
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = CFG_FRAME_MODE;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    magic_sync_length_deframer #(
        .BUF_BYTES(FRAME_CAP)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_link_item  pending_items[$];
    t_beat       expected_beats[$];
    int unsigned fail_count   = 0;
    int unsigned queued_count = 0;
    logic        hold_feed    = 1'b0;

    // Predictor copy of the registers and the frame assembly
    logic       cfg_mode      = MODE_SHORT;
    logic [7:0] cfg_magic_a   = MAGIC_RST;
    logic [7:0] cfg_magic_b   = MAGIC_RST;
    logic [9:0] cfg_min_total = MIN_TOTAL_RST;

    logic [7:0]  asm_hdr [8];
    int unsigned asm_count;
    bit          asm_in_body;
    int unsigned asm_offset;
    int unsigned asm_total;

    function automatic int unsigned header_len();
        return (cfg_mode == MODE_LONG) ? int'(HDR_LONG) : int'(HDR_SHORT);
    endfunction

    // Smallest accepted total under the current mode
    function automatic int unsigned size_floor();
        if (cfg_mode == MODE_LONG)
            return int'(LONG_MIN);
        return (cfg_min_total < SHORT_MIN) ? int'(SHORT_MIN) : int'(cfg_min_total);
    endfunction

    task automatic clear_assembly();
        int k;
        for (k = 0; k < 8; k++)
            asm_hdr[k] = 8'd0;
        asm_count   = 0;
        asm_in_body = 1'b0;
        asm_offset  = 0;
        asm_total   = 0;
    endtask

    initial clear_assembly();

    // Advance the predictor by one accepted link item
    task automatic absorb_item(input t_link_item it);
        int unsigned hlen;
        int unsigned total;
        int unsigned k;
        t_beat       beat;
        if (it.req == REQ_DROP) begin
            clear_assembly();
            return;
        end
        // Pass body bytes straight through
        if (asm_in_body) begin
            beat.out_byte       = it.data;
            beat.byte_offset    = asm_offset[OFFSET_W-1:0];
            beat.last_byte      = (asm_offset + 1 >= asm_total);
            beat.bad_size       = 1'b0;
            beat.declared_total = asm_total[TOTAL_W-1:0];
            expected_beats.push_back(beat);
            if (beat.last_byte)
                clear_assembly();
            else
                asm_offset++;
            return;
        end
        asm_hdr[asm_count & 7] = it.data;
        asm_count++;
        // Slide by one byte on a magic mismatch
        if (asm_count >= 2 && (asm_hdr[0] != cfg_magic_a || asm_hdr[1] != cfg_magic_b)) begin
            for (k = 0; k < 7; k++)
                asm_hdr[k] = asm_hdr[k+1];
            asm_hdr[7] = 8'd0;
            asm_count--;
            return;
        end
        hlen = header_len();
        if (asm_count < hlen)
            return;
        if (cfg_mode == MODE_LONG) begin
            total = {asm_hdr[2], asm_hdr[3]};
            total += LONG_EXTRA;
        end else begin
            total = {asm_hdr[5], asm_hdr[4]};
        end
        // Out-of-range total: one error item, then resync
        if (total < size_floor() || total > FRAME_CAP) begin
            beat = '0;
            beat.bad_size       = 1'b1;
            beat.declared_total = total[TOTAL_W-1:0];
            expected_beats.push_back(beat);
            clear_assembly();
            return;
        end
        // Release the buffered header
        for (k = 0; k < hlen; k++) begin
            beat.out_byte       = asm_hdr[k];
            beat.byte_offset    = k[OFFSET_W-1:0];
            beat.last_byte      = (k + 1 == total);
            beat.bad_size       = 1'b0;
            beat.declared_total = total[TOTAL_W-1:0];
            expected_beats.push_back(beat);
        end
        if (total == hlen) begin
            clear_assembly();
        end else begin
            clear_assembly();
            asm_in_body = 1'b1;
            asm_offset  = hlen;
            asm_total   = total;
        end
    endtask

    // Write one register and mirror it in the predictor
    task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_FRAME_MODE: begin
                cfg_mode = val[0];
                clear_assembly();
            end
            CFG_MAGIC_FIRST:  cfg_magic_a   = val[7:0];
            CFG_MAGIC_SECOND: cfg_magic_b   = val[7:0];
            CFG_MIN_TOTAL:    cfg_min_total = val[9:0];
            default: ;
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b);
        t_link_item it;
        it.req  = REQ_DATA;
        it.data = b;
        pending_items.push_back(it);
        queued_count++;
    endtask

    task automatic send_drop();
        t_link_item it;
        it.req  = REQ_DROP;
        it.data = 8'($urandom);
        pending_items.push_back(it);
        queued_count++;
    endtask

    // Header for a given total under the current mode and magic
    task automatic send_header(input logic [TOTAL_W-1:0] total);
        logic [15:0] len;
        send_byte(cfg_magic_a);
        send_byte(cfg_magic_b);
        if (cfg_mode == MODE_LONG) begin
            len = 16'(total - LONG_EXTRA);
            send_byte(len[15:8]);
            send_byte(len[7:0]);
            repeat (4) send_byte(8'($urandom));
        end else begin
            send_byte(8'($urandom));
            send_byte(8'($urandom));
            send_byte(total[7:0]);
            send_byte(total[15:8]);
        end
    endtask

    task automatic send_frame(input int unsigned total);
        send_header(total[TOTAL_W-1:0]);
        repeat (total - header_len()) send_byte(8'($urandom));
    endtask

    // One random piece of link traffic: mostly whole frames
    task automatic random_episode();
        int unsigned pick;
        int unsigned lo;
        int unsigned total;
        lo   = size_floor();
        pick = $urandom_range(99);
        if (pick < 66) begin
            total = lo + ((pick < 60) ? $urandom_range(20) : $urandom_range(100));
            if (total > FRAME_CAP)
                total = FRAME_CAP;
            send_frame(total);
        end else if (pick < 78) begin
            if (cfg_mode == MODE_SHORT && $urandom_range(1) == 0)
                total = $urandom_range(lo - 1, 0);
            else
                total = $urandom_range((cfg_mode == MODE_LONG) ? 65543 : 65535,
                                       FRAME_CAP + 1);
            send_header(total[TOTAL_W-1:0]);
        end else if (pick < 88) begin
            // Broken frame: cut off by a link drop
            if ($urandom_range(1) == 0) begin
                send_byte(cfg_magic_a);
            end else begin
                total = lo + 1 + $urandom_range(20);
                send_header(total[TOTAL_W-1:0]);
                repeat ($urandom_range(total - header_len() - 1)) send_byte(8'($urandom));
            end
            send_drop();
        end else begin
            repeat ($urandom_range(5, 1))
                send_byte(($urandom_range(2) == 0) ? cfg_magic_a : 8'($urandom));
        end
    endtask

    // Wait until every item is taken and every result has come
    task automatic settle();
        while (pending_items.size() != 0 || s_axis_tvalid || expected_beats.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Sender: bursts of random length with random gaps
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;
    t_link_item  fed_item;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                fed_item = pending_items.pop_front();
                absorb_item(fed_item);
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(24, 1);
                    gap_left   = ($urandom_range(1) == 0) ? 0 : $urandom_range(8, 1);
                end
            end
            // Hold a presented item until it is taken
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (!hold_feed && pending_items.size() != 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_items[0].data;
                    s_axis_tuser  <= pending_items[0].req;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Receiver: check each taken item, stall on a changing duty pattern
    int unsigned rx_tick   = 0;
    int unsigned rx_period = 4;
    int unsigned rx_busy   = 0;
    t_beat       want_beat;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_beats.size() == 0) begin
                $error("result item with nothing expected: tdata %h", m_axis_tdata);
                fail_count++;
            end else begin
                want_beat = expected_beats.pop_front();
                check_field("out_byte", want_beat.out_byte, m_axis_tdata[7:0]);
                check_field("byte_offset", want_beat.byte_offset, m_axis_tdata[16:8]);
                check_field("declared_total", want_beat.declared_total, m_axis_tdata[33:17]);
                check_field("last_byte", want_beat.last_byte, m_axis_tlast);
                check_field("bad_size", want_beat.bad_size, m_axis_tuser[0]);
            end
        end
        rx_tick++;
        if (rx_tick >= 64) begin
            rx_tick   = 0;
            rx_period = $urandom_range(12, 2);
            rx_busy   = ($urandom_range(2) == 0) ? 0 : $urandom_range(rx_period - 1, 1);
        end
        m_axis_tready <= ((rx_tick % rx_period) >= rx_busy);
    end

    initial begin
        #4_000_000;
        $display("FAIL magic_sync_length_deframer");
        $finish;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: drop, slide, short and long totals, drop mid-header
        send_drop();
        send_byte(8'h00); send_byte(8'h5A); send_byte(8'h5A); send_byte(8'hFF);
        send_byte(8'h00); send_byte(8'h06); send_byte(8'h00);
        send_byte(8'h5A); send_byte(8'h5A); send_byte(8'h11); send_byte(8'h22);
        send_byte(8'h01); send_byte(8'h02);
        send_byte(8'h5A); send_byte(8'h5A); send_byte(8'h33); send_drop();
        send_byte(8'h5A); send_byte(8'h5A); send_byte(8'h00); send_byte(8'h00);
        send_byte(8'hFF); send_byte(8'hFF);
        queued_count = 0;
        while (queued_count < 70) random_episode();
        settle();

        // Lowest minimum, odd magic: header-only packet and one-byte body
        write_reg(CFG_MIN_TOTAL, 10'd6);
        write_reg(CFG_MAGIC_FIRST, 10'h00);
        write_reg(CFG_MAGIC_SECOND, 10'hFF);
        send_byte(8'h00); send_byte(8'hFF); send_byte(8'hAA); send_byte(8'h55);
        send_byte(8'h06); send_byte(8'h00);
        send_frame(7);
        send_header(17'd5);
        queued_count = 0;
        while (queued_count < 80) random_episode();
        // Leave a header half built for the mode write to clear
        send_byte(8'h00); send_byte(8'hFF); send_byte(8'h03);
        settle();

        // Long headers
        write_reg(CFG_FRAME_MODE, 10'(MODE_LONG));
        write_reg(CFG_MAGIC_FIRST, 10'hFF);
        write_reg(CFG_MAGIC_SECOND, 10'h00);
        write_reg(CFG_MIN_TOTAL, 10'd512);
        send_frame(8);
        send_header(17'd65543);
        send_header(17'd513);
        send_frame(9);
        queued_count = 0;
        while (queued_count < 80) random_episode();
        settle();

        // Highest minimum: only a full-size total gets through
        write_reg(CFG_FRAME_MODE, 10'(MODE_SHORT));
        write_reg(CFG_MAGIC_FIRST, 10'(MAGIC_RST));
        write_reg(CFG_MAGIC_SECOND, 10'(MAGIC_RST));
        send_header(17'd511);
        send_header(17'(FRAME_CAP));
        repeat (10) send_byte(8'($urandom));
        send_drop();
        settle();

        // Small random minimum, with pauses until all results are out
        write_reg(CFG_MIN_TOTAL, 10'($urandom_range(30, 6)));
        queued_count = 0;
        repeat (2) begin
            while (queued_count < 35) random_episode();
            queued_count = 0;
            while (pending_items.size() > 15) @(posedge i_clk);
            hold_feed <= 1'b1;
            @(posedge i_clk);
            while (s_axis_tvalid || expected_beats.size() != 0) @(posedge i_clk);
            hold_feed <= 1'b0;
        end
        while (queued_count < 30) random_episode();
        settle();

        if (fail_count == 0)
            $display("PASS magic_sync_length_deframer");
        else
            $display("FAIL magic_sync_length_deframer");
        $finish;
    end

endmodule
